[hdl/pmw_pkg.sv]
// ----------------------------------------------------------------------------
// pmw_pkg
// Shared constants and types of the pairwise majority winner block.
// ----------------------------------------------------------------------------
package pmw_pkg;

    localparam int MAX_CANDIDATES = 64;
    localparam int CAND_W         = $clog2(MAX_CANDIDATES);
    localparam int CNT_W          = CAND_W + 1;
    localparam int TALLY_W        = 24;
    localparam int TALLY_DEPTH    = MAX_CANDIDATES * MAX_CANDIDATES;
    localparam int TALLY_AW       = $clog2(TALLY_DEPTH);
    localparam int VOTERS_W       = 24;
    localparam int CFG_AW         = 3;
    localparam int CFG_DW         = 32;

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    // register index, taken from paddr bit 2
    localparam logic REG_CANDIDATE_COUNT = 1'b0;
    localparam logic REG_TOTAL_VOTERS    = 1'b1;

    localparam logic [CNT_W-1:0]    CAND_COUNT_RESET = CNT_W'(4);
    localparam logic [VOTERS_W-1:0] VOTERS_RESET     = VOTERS_W'(1);

    // request action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECIDE = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]    n_eff;
        logic [VOTERS_W-2:0] half;
    } cfg_t;

    typedef struct packed {
        logic                we;
        logic [TALLY_AW-1:0] waddr;
        logic [TALLY_W-1:0]  wdata;
        logic [TALLY_AW-1:0] raddr;
    } tally_port_t;

    typedef struct packed {
        logic              we;
        logic [CAND_W-1:0] waddr;
        logic [CAND_W-1:0] wdata;
        logic [CAND_W-1:0] raddr;
    } list_port_t;

endpackage

[hdl/pmw_ram.sv]
// ----------------------------------------------------------------------------
// pmw_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pmw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pmw_cfg.sv]
// ----------------------------------------------------------------------------
// pmw_cfg
// APB register file: candidate count and total voters.
// ----------------------------------------------------------------------------
module pmw_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pmw_pkg::CFG_AW-1:0] paddr,
    input  logic [pmw_pkg::CFG_DW-1:0] pwdata,
    output logic [pmw_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output pmw_pkg::cfg_t              cfg
);
    import pmw_pkg::*;

    logic [CNT_W-1:0]    cand_count_reg, cand_count_next;
    logic [VOTERS_W-1:0] voters_reg, voters_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cand_count_next = cand_count_reg;
        voters_next     = voters_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_CANDIDATE_COUNT: cand_count_next = pwdata[CNT_W-1:0];
                REG_TOTAL_VOTERS:    voters_next     = pwdata[VOTERS_W-1:0];
                default:             cand_count_next = cand_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_count_reg <= CAND_COUNT_RESET;
            voters_reg     <= VOTERS_RESET;
        end
        else
        begin
            cand_count_reg <= cand_count_next;
            voters_reg     <= voters_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CANDIDATE_COUNT: prdata = CFG_DW'(cand_count_reg);
            REG_TOTAL_VOTERS:    prdata = CFG_DW'(voters_reg);
            default:             prdata = '0;
        endcase
    end

    // counts above the matrix size clamp to it
    assign cfg.n_eff = (cand_count_reg > CNT_W'(MAX_CANDIDATES)) ?
                       CNT_W'(MAX_CANDIDATES) : cand_count_reg;
    assign cfg.half  = voters_reg[VOTERS_W-1:1];

endmodule

[hdl/pmw_ctrl.sv]
// ----------------------------------------------------------------------------
// pmw_ctrl
// Sequencer: tally update pipeline, winner scan and matrix clearing pass.
// ----------------------------------------------------------------------------
module pmw_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pmw_pkg::cfg_t                cfg,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         action,
    input  logic [pmw_pkg::CAND_W-1:0]   candidate_id,
    input  logic [pmw_pkg::TALLY_W-1:0]  group_weight,
    input  logic                         end_of_list,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [pmw_pkg::CAND_W-1:0]   winner_id,
    output logic                         has_winner,
    output pmw_pkg::list_port_t          list_port,
    input  logic [pmw_pkg::CAND_W-1:0]   list_rdata,
    output pmw_pkg::tally_port_t         tally_port,
    input  logic [pmw_pkg::TALLY_W-1:0]  tally_rdata
);
    import pmw_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    list_len_reg, list_len_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    r_reg, r_next;
    logic                b_valid_reg, b_valid_next;
    logic                c_valid_reg, c_valid_next;
    logic                fwd_reg, fwd_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [TALLY_AW-1:0] clr_reg, clr_next;
    logic                res_valid_reg, res_valid_next;

    logic [CAND_W-1:0]   cand_reg, cand_next;
    logic [TALLY_W-1:0]  weight_reg, weight_next;
    logic [TALLY_AW-1:0] idx_c_reg, idx_c_next;
    logic [TALLY_W-1:0]  fwd_data_reg, fwd_data_next;
    logic [CAND_W-1:0]   winner_reg, winner_next;
    logic                has_reg, has_next;

    logic                item_accept;
    logic [TALLY_AW-1:0] idx_b;
    logic [TALLY_W-1:0]  old_tally;
    logic [TALLY_W:0]    sum;
    logic [TALLY_W-1:0]  sat_sum;

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_accept  = item_valid && item_ready;
    assign result_valid = res_valid_reg;
    assign winner_id    = winner_reg;
    assign has_winner   = has_reg;

    // the tally written last cycle may be the one read last cycle
    assign idx_b     = {list_rdata, cand_reg};
    assign old_tally = fwd_reg ? fwd_data_reg : tally_rdata;
    assign sum       = {1'b0, old_tally} + {1'b0, weight_reg};
    assign sat_sum   = sum[TALLY_W] ? TALLY_MAX : sum[TALLY_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        list_len_next  = list_len_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        b_valid_next   = b_valid_reg;
        c_valid_next   = c_valid_reg;
        fwd_next       = fwd_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        clr_next       = clr_reg;
        res_valid_next = res_valid_reg;
        cand_next      = cand_reg;
        weight_next    = weight_reg;
        idx_c_next     = idx_c_reg;
        fwd_data_next  = fwd_data_reg;
        winner_next    = winner_reg;
        has_next       = has_reg;

        list_port.we    = 1'b0;
        list_port.waddr = list_len_reg[CAND_W-1:0];
        list_port.wdata = candidate_id;
        list_port.raddr = r_reg[CAND_W-1:0];

        tally_port.we    = 1'b0;
        tally_port.waddr = idx_c_reg;
        tally_port.wdata = sat_sum;
        tally_port.raddr = idx_b;

        if (result_valid && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    if (action == ACT_LOAD)
                    begin
                        if (list_len_reg < cfg.n_eff)
                        begin
                            list_port.we = 1'b1;
                            cand_next    = candidate_id;
                            weight_next  = group_weight;
                            cnt_next     = list_len_reg;
                            r_next       = '0;
                            b_valid_next = 1'b0;
                            c_valid_next = 1'b0;
                            fwd_next     = 1'b0;
                            state_next   = ST_LOAD;
                            list_len_next = end_of_list ? '0 : list_len_reg + 1'b1;
                        end
                        else if (end_of_list)
                        begin
                            list_len_next = '0;
                        end
                    end
                    else
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_LOAD:
            begin
                // stage c: write back the updated tally
                tally_port.we = c_valid_reg;
                // stage b: list entry known, read its tally
                c_valid_next  = b_valid_reg;
                idx_c_next    = idx_b;
                fwd_next      = b_valid_reg && c_valid_reg && (idx_b == idx_c_reg);
                fwd_data_next = sat_sum;
                // stage a: read the next earlier list entry
                if (r_reg < cnt_reg)
                begin
                    b_valid_next = 1'b1;
                    r_next       = r_reg + 1'b1;
                end
                else
                begin
                    b_valid_next = 1'b0;
                    if (!b_valid_reg && !c_valid_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SCAN:
            begin
                tally_port.raddr = {i_reg[CAND_W-1:0], j_reg[CAND_W-1:0]};
                if (i_reg >= cfg.n_eff)
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        winner_next    = '0;
                        has_next       = 1'b0;
                        clr_next       = '0;
                        state_next     = ST_CLEAR;
                    end
                end
                else if (j_reg >= cfg.n_eff)
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        winner_next    = i_reg[CAND_W-1:0];
                        has_next       = 1'b1;
                        clr_next       = '0;
                        state_next     = ST_CLEAR;
                    end
                end
                else if (j_reg == i_reg)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // no majority over j: move on to the next candidate
                if (tally_rdata <= {1'b0, cfg.half})
                begin
                    i_next = i_reg + 1'b1;
                    j_next = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                state_next = ST_SCAN;
            end

            ST_CLEAR:
            begin
                tally_port.we    = 1'b1;
                tally_port.waddr = clr_reg;
                tally_port.wdata = '0;
                clr_next         = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            list_len_reg  <= '0;
            cnt_reg       <= '0;
            r_reg         <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_len_reg  <= list_len_next;
            cnt_reg       <= cnt_next;
            r_reg         <= r_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            fwd_reg       <= fwd_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        weight_reg   <= weight_next;
        idx_c_reg    <= idx_c_next;
        fwd_data_reg <= fwd_data_next;
        winner_reg   <= winner_next;
        has_reg      <= has_next;
    end

    a_tally_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        tally_port.we |-> (state_reg == ST_LOAD || state_reg == ST_CLEAR))
        else $error("tally written outside update or clearing pass");

    a_list_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        list_len_reg <= CNT_W'(MAX_CANDIDATES))
        else $error("list length beyond matrix size");

    a_scan_posts_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_CLEAR) |=> res_valid_reg)
        else $error("scan finished without a result");

    a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && state_next != ST_CLEAR) |-> (&clr_reg))
        else $error("clearing pass left early");

    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && state_next == ST_IDLE) |=> !c_valid_reg && !b_valid_reg)
        else $error("update pipeline left with entries in flight");

endmodule

[hdl/pairwise_majority_winner.sv]
// ----------------------------------------------------------------------------
// pairwise_majority_winner
// Tallies ranked lists into a pairwise matrix and reports the majority winner.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  apb       in / out   psel penable pwrite pready paddr pwdata prdata
//  item      in         item_valid item_ready      action candidate_id
//                                                  group_weight end_of_list
//  result    out        result_valid result_ready  winner_id has_winner
//
//  load request: stores the candidate unless the list is full, then updates its
//    tally against each earlier entry; a three-stage read-modify-write over the
//    tally memory, one entry a cycle, and no new request is taken until it drains
//  decide request: a scan of the tally entries, skipping the diagonal, then a
//    clearing pass over the tally memory
//  reset: a clearing pass runs before the first request is taken
//  the result register holds a result until taken; loads proceed meanwhile,
//    and a later decide waits for the register before posting its own
// ----------------------------------------------------------------------------
module pairwise_majority_winner (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pmw_pkg::CFG_AW-1:0]   paddr,
    input  logic [pmw_pkg::CFG_DW-1:0]   pwdata,
    output logic [pmw_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         action,
    input  logic [pmw_pkg::CAND_W-1:0]   candidate_id,
    input  logic [pmw_pkg::TALLY_W-1:0]  group_weight,
    input  logic                         end_of_list,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [pmw_pkg::CAND_W-1:0]   winner_id,
    output logic                         has_winner
);
    import pmw_pkg::*;

    cfg_t                cfg;
    list_port_t          list_port;
    tally_port_t         tally_port;
    logic [CAND_W-1:0]   list_rdata;
    logic [TALLY_W-1:0]  tally_rdata;

    pmw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pmw_ram #(
        .WIDTH (CAND_W),
        .DEPTH (MAX_CANDIDATES)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_port.we),
        .waddr (list_port.waddr),
        .wdata (list_port.wdata),
        .raddr (list_port.raddr),
        .rdata (list_rdata)
    );

    pmw_ram #(
        .WIDTH (TALLY_W),
        .DEPTH (TALLY_DEPTH)
    ) u_tally_ram (
        .clk   (clk),
        .we    (tally_port.we),
        .waddr (tally_port.waddr),
        .wdata (tally_port.wdata),
        .raddr (tally_port.raddr),
        .rdata (tally_rdata)
    );

    pmw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .candidate_id (candidate_id),
        .group_weight (group_weight),
        .end_of_list  (end_of_list),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .winner_id    (winner_id),
        .has_winner   (has_winner),
        .list_port    (list_port),
        .list_rdata   (list_rdata),
        .tally_port   (tally_port),
        .tally_rdata  (tally_rdata)
    );

endmodule
